FILE: rtl/core/fqd_pkg.sv
// Package for the FIFO queue with delete-by-value.
// Holds the request/response payload types, operation codes and field widths.
// No dependencies.
package fqd_pkg;

  localparam int FUNC_W = 2;
  localparam int ITEM_W = 32;
  localparam int LEN_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ITEM_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [ITEM_W-1:0] head_value;
    logic [LEN_W-1:0]  length;
  } rsp_t;

  // per-cell update command
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

FILE: rtl/core/fqd_cell.sv
// One storage cell of the queue chain: holds one entry and compares it.
// Loads a new value, or takes its right neighbor's entry on a shift.
// Depends on fqd_pkg.
module fqd_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  fqd_pkg::cell_ctl_t    ctl,
  input  logic                  occupied,
  input  logic [DATA_WIDTH-1:0] cmp_value,
  input  logic [DATA_WIDTH-1:0] next_entry,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = cmp_value;
    end else if (ctl.shift) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = occupied && (entry_r == cmp_value);

endmodule

FILE: rtl/core/fifo_queue_with_delete.sv
// Top level of the FIFO queue with delete-by-value: cell chain, control and
// result register. Depends on fqd_pkg and fqd_cell.
//
// Usage:
//   Requests arrive on in_valid/in_stall/in_data (func, item_value). Enqueue
//   appends a non-zero value at the tail, dequeue pops the head and returns
//   it in head_value, delete removes the first entry from the head that
//   equals item_value; later entries close up behind it.
//   Each request yields exactly one response on out_valid/out_stall/out_data
//   with status (0 ok, 1 error), head_value and the length after the request.
//   The response is registered at the edge that takes the request. Throughput
//   is one request per cycle while the receiver does not stall; every cell
//   compares its entry and shifts within that cycle, and the first-match
//   mask is a log-depth prefix OR over the cell match bits.
//   When the receiver stalls, the response register holds and in_stall rises
//   until the response transfers; a new request is taken in the same cycle
//   that the held response goes out.
//   Reset empties the queue (count to zero) and drops any pending response;
//   entry storage is not cleared and is only read below the count.
module fifo_queue_with_delete #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fqd_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output fqd_pkg::rsp_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  fqd_pkg::rsp_t         out_data_r;
  fqd_pkg::rsp_t         rsp_nxt;

  logic                  in_fire;
  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] val;
  logic                  val_zero;
  logic                  is_full;
  logic                  is_empty;
  logic                  enq_ok;
  logic                  deq_ok;
  logic                  del_ok;
  logic                  any_match;
  logic [63:0]           head_ext;

  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      first_mask;
  logic [DATA_WIDTH-1:0] entry [DEPTH];
  fqd_pkg::cell_ctl_t    ctl [DEPTH];

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  assign val_ext  = 64'(in_data.item_value);
  assign val      = val_ext[DATA_WIDTH-1:0];
  assign val_zero = (val == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // cells at or past the first match shift left on a delete
  always_comb begin
    first_mask = match;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      first_mask = first_mask | (first_mask << s);
    end
  end

  assign any_match = |match;

  assign enq_ok = (in_data.func == fqd_pkg::FUNC_ENQ) && !val_zero && !is_full;
  assign deq_ok = (in_data.func == fqd_pkg::FUNC_DEQ) && !is_empty;
  assign del_ok = (in_data.func == fqd_pkg::FUNC_DEL) && !val_zero && any_match;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] nbr;
      if (gi == DEPTH - 1) begin : g_last
        assign nbr = entry[gi];
      end else begin : g_mid
        assign nbr = entry[gi+1];
      end

      assign ctl[gi].load  = in_fire && enq_ok && (count_r == CW'(gi));
      assign ctl[gi].shift = in_fire && (deq_ok || (del_ok && first_mask[gi]));

      fqd_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl[gi]),
        .occupied   (CW'(gi) < count_r),
        .cmp_value  (val),
        .next_entry (nbr),
        .entry      (entry[gi]),
        .match      (match[gi])
      );
    end
  endgenerate

  assign head_ext = 64'(entry[0]);

  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (deq_ok || del_ok) begin
      count_nxt = CW'(count_r - 1'b1);
    end

    rsp_nxt.status     = (enq_ok || deq_ok || del_ok) ? fqd_pkg::ST_OK : fqd_pkg::ST_ERR;
    rsp_nxt.head_value = deq_ok ? head_ext[fqd_pkg::ITEM_W-1:0] : '0;
    rsp_nxt.length     = fqd_pkg::LEN_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_data_r.length == fqd_pkg::LEN_W'(count_r))
    else $error("reported length differs from count");

  a_err_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !(enq_ok || deq_ok || del_ok) |=> count_r == $past(count_r))
    else $error("failed request changed the count");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && enq_ok |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("enqueue did not grow the queue");

  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    is_empty |-> !any_match)
    else $error("match reported on empty queue");

endmodule

FILE: tb/fifo_queue_with_delete_tb.sv
// Testbench for fifo_queue_with_delete: directed and random requests, a built-in
// queue predictor and a per-field response check. Depends on fqd_pkg and the RTL.
module fifo_queue_with_delete_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH      = 16;
  localparam int WORD_W      = 32;
  localparam int CYCLE_LIMIT = 100000;
  localparam int TAIL_CYCLES = 4;

  localparam logic [fqd_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  fqd_pkg::req_t  in_data   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  fqd_pkg::rsp_t  out_data;

  // predictor state: queued words, head at index 0
  logic [WORD_W-1:0] held_words[$];
  fqd_pkg::rsp_t     expected_rsps[$];
  logic [WORD_W-1:0] value_pool[8];

  int send_idle_pct = 0;
  int rcv_idle_pct  = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int err_count     = 0;
  int cycle_cnt     = 0;

  fifo_queue_with_delete #(
    .DEPTH(QDEPTH),
    .DATA_WIDTH(WORD_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL fifo_queue_with_delete");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // response check against the oldest prediction
  always @(posedge clk) begin
    fqd_pkg::rsp_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response transfer: %p", out_data);
        err_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_data.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, out_data.status);
          err_count++;
        end
        if (out_data.head_value !== exp_rsp.head_value) begin
          $error("head_value: expected %h, actual %h",
                 exp_rsp.head_value, out_data.head_value);
          err_count++;
        end
        if (out_data.length !== exp_rsp.length) begin
          $error("length: expected %0d, actual %0d", exp_rsp.length, out_data.length);
          err_count++;
        end
      end
    end
  end

  // applies one request to the held words and returns the response it gives
  function automatic fqd_pkg::rsp_t queue_response(fqd_pkg::req_t r);
    fqd_pkg::rsp_t e;
    int            hit;
    e.status     = fqd_pkg::ST_ERR;
    e.head_value = '0;
    hit          = -1;
    case (r.func)
      fqd_pkg::FUNC_ENQ: begin
        if (r.item_value != '0 && held_words.size() < QDEPTH) begin
          held_words.push_back(r.item_value);
          e.status = fqd_pkg::ST_OK;
        end
      end
      fqd_pkg::FUNC_DEQ: begin
        if (held_words.size() > 0) begin
          e.head_value = held_words.pop_front();
          e.status = fqd_pkg::ST_OK;
        end
      end
      fqd_pkg::FUNC_DEL: begin
        if (r.item_value != '0) begin
          for (int i = 0; i < held_words.size() && hit < 0; i++)
            if (held_words[i] == r.item_value) hit = i;
          if (hit >= 0) begin
            held_words.delete(hit);
            e.status = fqd_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
    e.length = fqd_pkg::LEN_W'(held_words.size());
    return e;
  endfunction

  task automatic send_req(input logic [fqd_pkg::FUNC_W-1:0] func,
                          input logic [WORD_W-1:0] value);
    fqd_pkg::req_t r;
    r.func       = func;
    r.item_value = value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rsps.push_back(queue_response(r));
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return value_pool[$urandom_range(0, 7)];
    if (roll < 95) return $urandom;
    return '0;
  endfunction

  // enq_w sets the share of enqueues, steering the queue toward empty or full
  task automatic send_random_req(input int enq_w);
    logic [WORD_W-1:0] value;
    int                roll;
    roll  = $urandom_range(0, 99);
    value = $urandom;
    if (roll < enq_w) begin
      send_req(fqd_pkg::FUNC_ENQ, pick_value());
    end else if (roll < enq_w + (100 - enq_w) * 4 / 10) begin
      send_req(fqd_pkg::FUNC_DEQ, value);
    end else if (roll < 97) begin
      if (held_words.size() > 0 && $urandom_range(0, 3) != 0)
        value = held_words[$urandom_range(0, held_words.size() - 1)];
      else
        value = pick_value();
      send_req(fqd_pkg::FUNC_DEL, value);
    end else begin
      send_req(FUNC_UNUSED, value);
    end
  endtask

  task automatic test_empty_errors();
    send_req(fqd_pkg::FUNC_DEQ, 32'hFFFF_FFFF);
    send_req(fqd_pkg::FUNC_DEL, 32'd5);
    send_req(fqd_pkg::FUNC_ENQ, 32'd0);
    send_req(FUNC_UNUSED, 32'hA5A5_5A5A);
  endtask

  task automatic test_fill_to_full();
    send_req(fqd_pkg::FUNC_ENQ, 32'hFFFF_FFFF);
    send_req(fqd_pkg::FUNC_ENQ, 32'd1);
    send_req(fqd_pkg::FUNC_ENQ, 32'h8000_0000);
    send_req(fqd_pkg::FUNC_ENQ, 32'd1);
    for (int i = 4; i < QDEPTH; i++) send_req(fqd_pkg::FUNC_ENQ, 32'h100 + i);
    // one past full
    send_req(fqd_pkg::FUNC_ENQ, 32'h5555_5555);
  endtask

  task automatic test_delete_cases();
    send_req(fqd_pkg::FUNC_DEL, 32'd0);
    send_req(fqd_pkg::FUNC_DEL, 32'h1234_5678);
    // duplicate value: only the first copy goes
    send_req(fqd_pkg::FUNC_DEL, 32'd1);
    send_req(fqd_pkg::FUNC_DEQ, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_ops(input int n_items, input int snd_pct, input int rcv_pct);
    int enq_w;
    send_idle_pct = snd_pct;
    rcv_idle_pct  = rcv_pct;
    enq_w = 45;
    for (int i = 0; i < 8; i++)
      value_pool[i] = (i < 2) ? WORD_W'($urandom_range(1, 3)) : $urandom;
    value_pool[7] = 32'hFFFF_FFFF;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_w = 15;
          1:       enq_w = 45;
          default: enq_w = 75;
        endcase
      end
      send_random_req(enq_w);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    hold_request  = 80;
    for (int i = 0; i < 40; i++) send_random_req(60);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_errors();
    test_fill_to_full();
    test_delete_cases();
    test_random_ops(370, 12, 55);
    test_random_ops(370, 55, 12);
    test_random_ops(370, 0, 0);
    test_backpressure();

    in_valid <= 1'b0;
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS fifo_queue_with_delete");
    end else begin
      $display("FAIL fifo_queue_with_delete");
    end
    $finish;
  end

endmodule
